[rtl/ifne_pkg.sv]
// Shared types and constants of the integrate-and-fire network event unit.
`default_nettype none
package ifne_pkg;

   // Input transfer payload.
   typedef struct packed {
      logic [1:0]  opcode;
      logic [9:0]  neuron;
      logic [3:0]  word_index;
      logic [63:0] write_data;
      logic [16:0] decay_factor;
   } req_type;

   // Result transfer payload.
   typedef struct packed {
      logic        fired;
      logic [10:0] cascade_size;
      logic [31:0] read_value;
   } rsp_type;

   // Opcodes.
   localparam logic [1:0] OP_VOLT  = 2'd0;
   localparam logic [1:0] OP_CONN  = 2'd1;
   localparam logic [1:0] OP_EVENT = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_KICK = 2'd0;
   localparam logic [1:0] CSR_COUP = 2'd1;

   localparam logic [16:0] KICK_RESET = 17'd1311;
   localparam logic [16:0] COUP_RESET = 17'd131;

   // Neuron memory word: {spike count, fired mark, voltage}.
   localparam int VW = 18;
   localparam int CNTW = 32;
   localparam int NW = CNTW + 1 + VW;
   localparam int MARK_BIT = VW;

   localparam logic [17:0] V_ONE = 18'h10000;
   localparam logic [18:0] V_MAX = 19'h3FFFF;
   localparam logic [16:0] DECAY_ONE = 17'h10000;
   localparam logic [10:0] SIZE_MAX = 11'h7FF;

endpackage
`default_nettype wire

[rtl/ifne_ram.sv]
// Simple dual-port synchronous memory with one registered read port.
`default_nettype none
module ifne_ram #(
   parameter int W = 8,
   parameter int D = 2
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [$clog2(D)-1:0] wa,
   input  wire logic [W-1:0]         wd,
   input  wire logic [$clog2(D)-1:0] ra,
   output logic      [W-1:0]         rd
);

   logic [W-1:0] mem [D];
   logic [W-1:0] rd_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[ra];
   end

   assign rd = rd_ff;

endmodule
`default_nettype wire

[rtl/integrate_fire_network_event_unit.sv]
// Top level: sequencer of the integrate-and-fire network event unit.
// Usage: an item on req_ (valid/stall) carries one opcode. Write voltage and
// read count pass through a read-modify-write step, and a connection word
// write goes straight to its result. An input-spike event sweeps the neuron
// memory once to decay every voltage, then runs the cascade, in which each
// firing neuron walks its whole connection row through the single
// read port of the neuron memory. One item is in work at a time; its result
// waits in an output register on rsp_ (valid/stall), so the next item may be
// accepted while a result is still stalled. A further finished result then
// waits until that register frees. Configuration writes on csr_ are always
// ready and take effect at once; the user must issue them only while the unit
// is idle; the unit does not enforce it. After reset the unit sweeps the neuron
// memory to clear all spike counts and holds req_stall high until it finishes.
// The sweep also zeroes every voltage; connection words are undefined until written.
`default_nettype none
module integrate_fire_network_event_unit #(
   parameter int NEURONS = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ifne_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ifne_pkg::rsp_type     rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [16:0]      csr_data
);

   localparam int AW = $clog2(NEURONS);
   localparam int WORDS = (NEURONS + 63) / 64;
   localparam int CDEPTH = NEURONS * WORDS;
   localparam int CAW = $clog2(CDEPTH);
   localparam logic [AW:0] NCNT = (AW + 1)'(NEURONS);
   localparam logic [12:0] NLIM = 13'(NEURONS);
   localparam logic [6:0] WLIM = 7'(WORDS);

   localparam logic [3:0] ST_CLR   = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_RMW   = 4'd2;
   localparam logic [3:0] ST_DECAY = 4'd3;
   localparam logic [3:0] ST_POP   = 4'd4;
   localparam logic [3:0] ST_SRCRD = 4'd5;
   localparam logic [3:0] ST_SRCWR = 4'd6;
   localparam logic [3:0] ST_SCAN  = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   // Registers.
   logic [3:0]    state_ff, state_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic [AW:0]   sp_ff, sp_in;
   logic [1:0]    op_ff, op_in;
   logic [AW-1:0] n_ff, n_in;
   logic [17:0]   vdata_ff, vdata_in;
   logic [16:0]   decay_ff, decay_in;
   logic [AW-1:0] src_ff, src_in;
   logic [CAW-1:0] row_ff, row_in;
   logic          fire_ff, fire_in;
   logic [10:0]   size_ff, size_in;
   ifne_pkg::rsp_type res_ff, res_in;
   ifne_pkg::rsp_type rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [16:0]   kick_ff, kick_in;
   logic [16:0]   coup_ff, coup_in;

   // Memory ports.
   logic                  nwe, cwe, swe;
   logic [AW-1:0]         nwa, nra, swa, sra;
   logic [ifne_pkg::NW-1:0] nwd, nrd;
   logic [CAW-1:0]        cwa, cra;
   logic [63:0]           crd;
   logic [AW-1:0]         swd, srd;

   ifne_ram #(.W(ifne_pkg::NW), .D(NEURONS)) u_nrn_mem (
      .clock(clock), .we(nwe), .wa(nwa), .wd(nwd), .ra(nra), .rd(nrd)
   );
   ifne_ram #(.W(64), .D(CDEPTH)) u_conn_mem (
      .clock(clock), .we(cwe), .wa(cwa), .wd(req_data.write_data), .ra(cra), .rd(crd)
   );
   ifne_ram #(.W(AW), .D(NEURONS)) u_stack_mem (
      .clock(clock), .we(swe), .wa(swa), .wd(swd), .ra(sra), .rd(srd)
   );

   // Decoded input and datapath terms.
   logic          accept, in_range, word_ok;
   logic [AW-1:0] n_req, idx, bidx;
   logic [5:0]    bpos;
   logic [17:0]   v, dv, kv, cv;
   logic [34:0]   prod;
   logic [18:0]   ksum, csum;
   logic [31:0]   cnt_rd;
   logic          is_tgt, fire_now, take;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid & ~req_stall;
   assign in_range = ({3'b0, req_data.neuron} < NLIM);
   assign word_ok = ({3'b0, req_data.word_index} < WLIM);
   assign n_req = AW'({3'b0, req_data.neuron});
   assign idx = cnt_ff[AW-1:0];
   assign bidx = AW'(cnt_ff - 1'b1);
   assign bpos = 6'(bidx);

   // Decay, kick and coupling arithmetic on the word read last cycle.
   assign v = nrd[17:0];
   assign cnt_rd = nrd[ifne_pkg::NW-1 -: ifne_pkg::CNTW];
   assign prod = 35'(v) * 35'(decay_ff);
   assign dv = prod[33:16];
   assign ksum = {1'b0, dv} + {2'b0, kick_ff};
   assign kv = (ksum > ifne_pkg::V_MAX) ? 18'(ifne_pkg::V_MAX) : ksum[17:0];
   assign is_tgt = (bidx == n_ff);
   assign fire_now = is_tgt && (kv > ifne_pkg::V_ONE);
   assign csum = {1'b0, v} + {2'b0, coup_ff};
   assign cv = (csum > ifne_pkg::V_MAX) ? 18'(ifne_pkg::V_MAX) : csum[17:0];
   assign take = crd[bpos] && (bidx != src_ff) && !nrd[ifne_pkg::MARK_BIT];

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      sp_in = sp_ff;
      op_in = op_ff;
      n_in = n_ff;
      vdata_in = vdata_ff;
      decay_in = decay_ff;
      src_in = src_ff;
      row_in = row_ff;
      fire_in = fire_ff;
      size_in = size_ff;
      res_in = res_ff;
      nwe = 1'b0;
      nwa = bidx;
      nwd = '0;
      nra = idx;
      cwe = 1'b0;
      cwa = CAW'(n_req * WORDS) + CAW'(req_data.word_index);
      cra = row_ff + CAW'(idx >> 6);
      swe = 1'b0;
      swa = sp_ff[AW-1:0];
      swd = bidx;
      sra = AW'(sp_ff - 1'b1);
      unique case (state_ff)
         ST_CLR: begin
            nwe = 1'b1;
            nwa = idx;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == NCNT - 1'b1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            nra = n_req;
            if (accept) begin
               op_in = req_data.opcode;
               n_in = n_req;
               vdata_in = req_data.write_data[17:0];
               decay_in = (req_data.decay_factor > ifne_pkg::DECAY_ONE) ?
                          ifne_pkg::DECAY_ONE : req_data.decay_factor;
               res_in = '0;
               cnt_in = '0;
               fire_in = 1'b0;
               size_in = '0;
               if (!in_range) begin
                  state_in = ST_DONE;
               end else begin
                  unique case (req_data.opcode)
                     ifne_pkg::OP_CONN: begin
                        cwe = word_ok;
                        state_in = ST_DONE;
                     end
                     ifne_pkg::OP_EVENT: state_in = ST_DECAY;
                     default: state_in = ST_RMW;
                  endcase
               end
            end
         end
         ST_RMW: begin
            if (op_ff == ifne_pkg::OP_VOLT) begin
               nwe = 1'b1;
               nwa = n_ff;
               nwd = {nrd[ifne_pkg::NW-1:ifne_pkg::VW], vdata_ff};
            end else begin
               res_in.read_value = cnt_rd;
            end
            state_in = ST_DONE;
         end
         ST_DECAY: begin
            // Read entry cnt while writing back entry cnt-1.
            if (cnt_ff != '0) begin
               nwe = 1'b1;
               nwd = {cnt_rd, fire_now, is_tgt ? kv : dv};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == NCNT) begin
               if (fire_ff || fire_now) begin
                  swe = 1'b1;
                  swa = '0;
                  swd = n_ff;
                  sp_in = (AW + 1)'(1);
                  state_in = ST_POP;
               end else begin
                  state_in = ST_DONE;
               end
            end
            fire_in = fire_ff || (cnt_ff != '0 && fire_now);
         end
         ST_POP: begin
            if (sp_ff == '0) begin
               res_in.fired = 1'b1;
               res_in.cascade_size = size_ff;
               state_in = ST_DONE;
            end else begin
               sp_in = sp_ff - 1'b1;
               state_in = ST_SRCRD;
            end
         end
         ST_SRCRD: begin
            src_in = srd;
            nra = srd;
            row_in = CAW'(srd * WORDS);
            state_in = ST_SRCWR;
         end
         ST_SRCWR: begin
            // Fire the source: clear its voltage and raise its count.
            nwe = 1'b1;
            nwa = src_ff;
            nwd = {(cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1, 1'b1, 18'd0};
            if (size_ff != ifne_pkg::SIZE_MAX) begin
               size_in = size_ff + 1'b1;
            end
            cnt_in = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // Read target cnt while updating target cnt-1.
            if (cnt_ff != '0 && take) begin
               nwe = 1'b1;
               nwd = {cnt_rd, cv >= ifne_pkg::V_ONE, cv};
               if (cv >= ifne_pkg::V_ONE) begin
                  swe = 1'b1;
                  sp_in = sp_ff + 1'b1;
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == NCNT) begin
               state_in = ST_POP;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register.
   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_in = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   // Configuration registers.
   assign csr_ready = 1'b1;
   always_comb begin
      kick_in = kick_ff;
      coup_in = coup_ff;
      if (csr_valid) begin
         if (csr_index == ifne_pkg::CSR_KICK) begin
            kick_in = csr_data;
         end else if (csr_index == ifne_pkg::CSR_COUP) begin
            coup_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         cnt_ff <= '0;
         sp_ff <= '0;
         rsp_valid_ff <= 1'b0;
         kick_ff <= ifne_pkg::KICK_RESET;
         coup_ff <= ifne_pkg::COUP_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         sp_ff <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
         kick_ff <= kick_in;
         coup_ff <= coup_in;
      end
      op_ff <= op_in;
      n_ff <= n_in;
      vdata_ff <= vdata_in;
      decay_ff <= decay_in;
      src_ff <= src_in;
      row_ff <= row_in;
      fire_ff <= fire_in;
      size_ff <= size_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

[rtl/ifne_checker.sv]
// Port-level assertions of the event unit and their bind.
`default_nettype none
module ifne_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire ifne_pkg::rsp_type rsp_data
);

   // A stalled result transfer holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // No cascade means no cascade size.
   a_no_fire_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.fired |-> rsp_data.cascade_size == 11'd0)
      else $error("cascade size without firing");

   // A cascade counts at least its start neuron and never carries a count read.
   a_fire_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fired |->
         rsp_data.cascade_size != 11'd0 && rsp_data.read_value == 32'd0)
      else $error("bad cascade result");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind integrate_fire_network_event_unit ifne_checker u_ifne_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
`default_nettype wire

[dv/integrate_fire_network_event_unit_tb.sv]
// Self-checking testbench of the integrate-and-fire network event unit.
`default_nettype none
module integrate_fire_network_event_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NEURONS = 1024;
   localparam int WORDS = NEURONS / 64;
   // Neurons 0 to LIVE-1 and the last neuron carry all events and connections.
   // Only their connection rows are written, so only they can ever fire.
   localparam int LIVE = 8;
   localparam int LIMIT = 12000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   ifne_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   ifne_pkg::rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [1:0]  csr_index = '0;
   logic [16:0] csr_data = '0;

   integrate_fire_network_event_unit #(.NEURONS(NEURONS)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // Shadow copy of the network state.
   logic [16:0] kick_reg;
   logic [16:0] coup_reg;
   logic [17:0] voltage_mem [NEURONS];
   logic [63:0] row_mem [NEURONS*WORDS];
   logic [31:0] spike_cnt [NEURONS];
   bit          fire_mark [NEURONS];
   int unsigned fire_stack [NEURONS];

   ifne_pkg::rsp_type pending_rsp [$];
   int          errors = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   longint      cycles = 0;

   function automatic logic [17:0] sat_add(logic [17:0] v, logic [16:0] inc);
      logic [18:0] s;
      s = {1'b0, v} + {2'b0, inc};
      return (s > ifne_pkg::V_MAX) ? 18'h3FFFF : s[17:0];
   endfunction

   // Runs the cascade that starts at one neuron and returns its size.
   function automatic int unsigned network_cascade(int unsigned start);
      int unsigned size;
      int unsigned depth;
      int unsigned src;
      logic [63:0] w;
      size = 0;
      depth = 0;
      foreach (fire_mark[i]) fire_mark[i] = 1'b0;
      fire_stack[depth++] = start;
      fire_mark[start] = 1'b1;
      while (depth > 0) begin
         src = fire_stack[--depth];
         size++;
         if (spike_cnt[src] != 32'hFFFFFFFF) spike_cnt[src]++;
         voltage_mem[src] = '0;
         for (int i = 0; i < NEURONS; i++) begin
            w = row_mem[src*WORDS + i/64];
            if (i == src || fire_mark[i] || !w[i%64]) continue;
            voltage_mem[i] = sat_add(voltage_mem[i], coup_reg);
            if (voltage_mem[i] >= ifne_pkg::V_ONE && depth < NEURONS) begin
               fire_mark[i] = 1'b1;
               fire_stack[depth++] = i;
            end
         end
      end
      return size;
   endfunction

   // Applies one item to the shadow state and returns its result.
   function automatic ifne_pkg::rsp_type network_step(ifne_pkg::req_type r);
      ifne_pkg::rsp_type o;
      logic [16:0] d;
      int unsigned c;
      o = '0;
      case (r.opcode)
         ifne_pkg::OP_VOLT: voltage_mem[r.neuron] = r.write_data[17:0];
         ifne_pkg::OP_CONN: row_mem[r.neuron*WORDS + r.word_index] = r.write_data;
         ifne_pkg::OP_EVENT: begin
            d = (r.decay_factor > ifne_pkg::DECAY_ONE) ? ifne_pkg::DECAY_ONE : r.decay_factor;
            for (int i = 0; i < NEURONS; i++)
               voltage_mem[i] = 18'((36'(voltage_mem[i]) * 36'(d)) >> 16);
            voltage_mem[r.neuron] = sat_add(voltage_mem[r.neuron], kick_reg);
            if (voltage_mem[r.neuron] > ifne_pkg::V_ONE) begin
               c = network_cascade(r.neuron);
               o.fired = 1'b1;
               o.cascade_size = (c > 2047) ? ifne_pkg::SIZE_MAX : 11'(c);
            end
         end
         default: o.read_value = spike_cnt[r.neuron];
      endcase
      return o;
   endfunction

   // Drives one item and waits for its transfer; the expectation is queued on acceptance.
   task automatic send_req(ifne_pkg::req_type r, bit typed, ifne_pkg::rsp_type typed_rsp);
      ifne_pkg::rsp_type p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = network_step(r);
      pending_rsp = {pending_rsp, typed ? typed_rsp : p};
   endtask

   task automatic send_plain(ifne_pkg::req_type r);
      send_req(r, 1'b0, '0);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Register writes happen only with the unit idle.
   task automatic csr_write(logic [1:0] idx, logic [16:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == ifne_pkg::CSR_KICK) kick_reg = val;
      else coup_reg = val;
   endtask

   function automatic ifne_pkg::req_type mk(logic [1:0] op, logic [9:0] n, logic [3:0] wi,
                                            logic [63:0] wd, logic [16:0] dk);
      ifne_pkg::req_type r;
      r.opcode = op;
      r.neuron = n;
      r.word_index = wi;
      r.write_data = wd;
      r.decay_factor = dk;
      return r;
   endfunction

   // Picks one of the neurons that carry the network activity.
   function automatic logic [9:0] live_neuron();
      int unsigned k;
      k = $urandom_range(LIVE);
      return (k == LIVE) ? 10'(NEURONS - 1) : 10'(k);
   endfunction

   // Sparse connection words link the live neurons only; voltages may go anywhere.
   function automatic ifne_pkg::req_type random_item(bit quiet_net);
      logic [63:0] wd;
      int          pick;
      pick = $urandom_range(99);
      wd = {$urandom(), $urandom()};
      if (pick < 30) begin
         if ($urandom_range(3) != 0) wd[17:0] = 18'(ifne_pkg::V_ONE - $urandom_range(3000));
         return mk(ifne_pkg::OP_VOLT,
                   ($urandom_range(3) != 0) ? live_neuron() : 10'($urandom()),
                   4'($urandom()), wd, 17'($urandom()));
      end else if (pick < 50) begin
         wd = wd & {$urandom(), $urandom()} & 64'hFF;
         if (quiet_net) wd = '0;
         if ($urandom_range(9) != 0)
            return mk(ifne_pkg::OP_CONN, live_neuron(), 4'd0, wd, 17'($urandom()));
         return mk(ifne_pkg::OP_CONN, live_neuron(), 4'(WORDS - 1),
                   ($urandom_range(1) != 0) ? 64'h8000000000000000 : 64'd0,
                   17'($urandom()));
      end else if (pick < 85) begin
         return mk(ifne_pkg::OP_EVENT, live_neuron(), 4'($urandom()), wd,
                   ($urandom_range(4) != 0) ? 17'($urandom_range(60000, 65536)) :
                                              17'($urandom()));
      end
      return mk(ifne_pkg::OP_READ, 10'($urandom()), 4'($urandom()), wd, 17'($urandom()));
   endfunction

   // Result checker and random receiver stall.
   always @(posedge clock) begin
      if (!reset) begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $error("result transfer with nothing expected");
               errors++;
            end else begin
               ifne_pkg::rsp_type e;
               e = pending_rsp.pop_front();
               if (rsp_data.fired !== e.fired) begin
                  $error("fired: expected %0d actual %0d", e.fired, rsp_data.fired);
                  errors++;
               end
               if (rsp_data.cascade_size !== e.cascade_size) begin
                  $error("cascade_size: expected %0d actual %0d",
                         e.cascade_size, rsp_data.cascade_size);
                  errors++;
               end
               if (rsp_data.read_value !== e.read_value) begin
                  $error("read_value: expected %0d actual %0d", e.read_value, rsp_data.read_value);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   typedef struct {
      ifne_pkg::req_type r;
      bit      typed;
      ifne_pkg::rsp_type e;
   } directed_row;

   directed_row plan [$];

   initial begin
      ifne_pkg::rsp_type z;
      z = '0;
      kick_reg = ifne_pkg::KICK_RESET;
      coup_reg = ifne_pkg::COUP_RESET;
      foreach (spike_cnt[i]) spike_cnt[i] = '0;
      foreach (voltage_mem[i]) voltage_mem[i] = '0;
      foreach (row_mem[i]) row_mem[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Give the whole connection row of every live neuron a defined value.
      for (int n = 0; n <= LIVE; n++) begin
         for (int w = 0; w < WORDS; w++) begin
            send_plain(mk(ifne_pkg::OP_CONN, (n == LIVE) ? 10'(NEURONS - 1) : 10'(n),
                          4'(w), '0, '0));
         end
      end

      // Directed table: extremes, thresholds and each opcode.
      plan = '{
         '{mk(ifne_pkg::OP_READ, 10'd0, 4'd0, '1, '1), 1'b1, '{1'b0, 11'd0, 32'd0}},
         '{mk(ifne_pkg::OP_READ, 10'd1023, 4'hF, '0, '0), 1'b1, '{1'b0, 11'd0, 32'd0}},
         '{mk(ifne_pkg::OP_VOLT, 10'd5, 4'hF, '1, '1), 1'b1, '{1'b0, 11'd0, 32'd0}},
         // Decay above 1.0 saturates; the full-scale voltage then fires alone.
         '{mk(ifne_pkg::OP_EVENT, 10'd5, 4'd0, '0, 17'h1FFFF), 1'b1, '{1'b1, 11'd1, 32'd0}},
         '{mk(ifne_pkg::OP_READ, 10'd5, 4'd0, '0, '0), 1'b1, '{1'b0, 11'd0, 32'd1}},
         // Kick landing exactly on 1.0 does not fire.
         '{mk(ifne_pkg::OP_VOLT, 10'd7, 4'd0, 64'd64225, '0), 1'b1, '{1'b0, 11'd0, 32'd0}},
         '{mk(ifne_pkg::OP_EVENT, 10'd7, 4'd0, '0, 17'h10000), 1'b1, '{1'b0, 11'd0, 32'd0}},
         '{mk(ifne_pkg::OP_VOLT, 10'd7, 4'd0, 64'd64226, '0), 1'b1, '{1'b0, 11'd0, 32'd0}},
         '{mk(ifne_pkg::OP_EVENT, 10'd7, 4'd0, '0, 17'h10000), 1'b1, '{1'b1, 11'd1, 32'd0}},
         // Zero decay wipes every voltage before the kick lands on the target.
         '{mk(ifne_pkg::OP_EVENT, 10'd1023, 4'd0, '0, 17'd0), 1'b1, '{1'b0, 11'd0, 32'd0}},
         // Small chain 1 -> 2 -> 3 -> 1023 with a self connection and back edges.
         '{mk(ifne_pkg::OP_CONN, 10'd1, 4'd0, 64'h6, '0), 1'b0, z},
         '{mk(ifne_pkg::OP_CONN, 10'd2, 4'd0, 64'hA, '0), 1'b0, z},
         '{mk(ifne_pkg::OP_CONN, 10'd3, 4'd0, 64'h4, '0), 1'b0, z},
         '{mk(ifne_pkg::OP_CONN, 10'd3, 4'hF, 64'h8000000000000000, '0), 1'b0, z},
         '{mk(ifne_pkg::OP_VOLT, 10'd2, 4'd0, 64'd65405, '0), 1'b0, z},
         '{mk(ifne_pkg::OP_VOLT, 10'd3, 4'd0, 64'd65405, '0), 1'b0, z},
         '{mk(ifne_pkg::OP_VOLT, 10'd1023, 4'd0, 64'h3FFF0, '0), 1'b0, z},
         '{mk(ifne_pkg::OP_VOLT, 10'd1, 4'd0, 64'h3FFFF, '0), 1'b0, z},
         '{mk(ifne_pkg::OP_EVENT, 10'd1, 4'd0, '0, 17'h10000), 1'b0, z},
         '{mk(ifne_pkg::OP_READ, 10'd1023, 4'd0, '0, '0), 1'b0, z},
         '{mk(ifne_pkg::OP_READ, 10'd3, 4'd0, '0, '0), 1'b0, z},
         '{mk(ifne_pkg::OP_CONN, 10'd3, 4'hF, 64'h0, '0), 1'b0, z}
      };
      foreach (plan[i]) send_req(plan[i].r, plan[i].typed, plan[i].e);

      // Extreme settings with only a few items.
      csr_write(ifne_pkg::CSR_KICK, 17'h10000);
      csr_write(ifne_pkg::CSR_COUP, 17'h10000);
      for (int i = 0; i < 8; i++) send_plain(random_item(1'b0));
      csr_write(ifne_pkg::CSR_KICK, 17'd0);
      csr_write(ifne_pkg::CSR_COUP, 17'd0);
      for (int i = 0; i < 8; i++) send_plain(random_item(1'b0));

      // Random phases with three idling profiles.
      for (int ph = 0; ph < 3; ph++) begin
         csr_write(ifne_pkg::CSR_KICK, 17'($urandom_range(500, 8000)));
         csr_write(ifne_pkg::CSR_COUP, 17'($urandom_range(100, 6000)));
         send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 70 : 0;
         recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 37 : 0;
         for (int i = 0; i < 36; i++) send_plain(random_item(1'b0));
      end

      drain();
      recv_idle_pct = 0;
      repeat (2200) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
